// ===== rtl/bfr_pkg.sv =====
// shared types and constants of the brightness fade ramp
package bfr_pkg;

  localparam int LVL_W   = 8;
  localparam int DUR_W   = 20;
  localparam int ACT_W   = 2;
  localparam int ITER_W  = $clog2(DUR_W + 1);
  localparam int LVL_MAX = 255;

  localparam int STEP_TIME_MS  = 100;
  localparam int MIN_INCREMENT = 2;
  localparam int MIN_STEPS     = 3;

  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [LVL_W-1:0] target_level;
    logic [DUR_W-1:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] brightness;
    logic             fade_start;
    logic             fade_end;
    logic             fading;
  } out_word_t;

  typedef enum logic [1:0] {
    DIV_INTERVAL,
    DIV_INC
  } div_op_e;

  typedef enum logic [2:0] {
    COMMIT_NONE,
    COMMIT_TICK,
    COMMIT_SET,
    COMMIT_EQUAL,
    COMMIT_JUMP,
    COMMIT_FADE
  } commit_e;

  typedef struct packed {
    logic    load_in;
    logic    prep;
    logic    div_start;
    div_op_e div_op;
    logic    take_steps;
    logic    take_interval;
    logic    take_inc;
    logic    commit;
    commit_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             at_goal;
    logic             running;
    logic             steps_small;
    logic             div_done;
    logic             out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/bfr_div.sv =====
// restoring serial divider, one quotient bit per cycle
module bfr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bfr_pkg::DUR_W-1:0]   dividend_i,
  input  logic [bfr_pkg::DUR_W-1:0]   divisor_i,
  input  logic [bfr_pkg::ITER_W-1:0]  iters_i,
  output logic                        done_o,
  output logic [bfr_pkg::DUR_W-1:0]   quotient_o
);

  localparam int W = bfr_pkg::DUR_W;

  logic [W-1:0]              rem_q, rem_d;
  logic [W-1:0]              dvd_q, dvd_d;
  logic [W-1:0]              dvs_q;
  logic [bfr_pkg::ITER_W-1:0] cnt_q;
  logic                      done_q;
  logic [W:0]                trial;
  logic                      qbit;

  always_comb begin
    trial = {rem_q, dvd_q[W-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    if (qbit) begin
      rem_d = W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[W-1:0];
    end
    dvd_d = {dvd_q[W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= iters_i;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == bfr_pkg::ITER_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== rtl/bfr_dp.sv =====
// fader datapath: fade state, step arithmetic, divider and result register
module bfr_dp #(
  parameter int StepTimeMs   = bfr_pkg::STEP_TIME_MS,
  parameter int MinIncrement = bfr_pkg::MIN_INCREMENT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfr_pkg::in_word_t    in_data_i,
  input  bfr_pkg::ctrl_cmd_t   cmd_i,
  output bfr_pkg::ctrl_sts_t   sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bfr_pkg::out_word_t   out_data_o
);

  localparam int LvlW      = bfr_pkg::LVL_W;
  localparam int DurW      = bfr_pkg::DUR_W;
  localparam int StepsW    = $clog2(bfr_pkg::LVL_MAX / MinIncrement + 1);
  localparam int LimW      = DurW + $clog2(MinIncrement + 1);
  localparam int DiffProdW = LvlW + $clog2(StepTimeMs + 1);
  localparam int CmpW      = (LimW > DiffProdW) ? LimW : DiffProdW;

  // reciprocals for the step count: floor(x / d) = (x * ceil(2^(n+l) / d)) >> (n+l)
  // with l = clog2(d), exact for every n-bit x
  localparam int     DurShift = DurW + $clog2(StepTimeMs);
  localparam int     DurProdW = 2 * DurW + 2;
  localparam longint DurRecip = ((longint'(1) << DurShift) + longint'(StepTimeMs) - 1)
                                / longint'(StepTimeMs);
  localparam int     LvlShift = LvlW + $clog2(MinIncrement);
  localparam int     LvlProdW = 2 * LvlW + 2;
  localparam longint LvlRecip = ((longint'(1) << LvlShift) + longint'(MinIncrement) - 1)
                                / longint'(MinIncrement);

  bfr_pkg::in_word_t  in_q;
  bfr_pkg::out_word_t out_q, out_d;
  logic               out_valid_q;

  logic [LvlW-1:0]   level_now_q, level_now_d;
  logic [LvlW-1:0]   level_goal_q, level_goal_d;
  logic [LvlW-1:0]   step_delta_q, step_delta_d;
  logic [StepsW-1:0] steps_left_q, steps_left_d;
  logic [DurW-1:0]   tick_int_q, tick_int_d;
  logic [DurW-1:0]   tick_cnt_q, tick_cnt_d;
  logic              running_q, running_d;

  logic              big_q;
  logic [StepsW-1:0] cal_steps_q;
  logic [DurW-1:0]   cal_int_q;
  logic [LvlW-1:0]   cal_delta_q;

  logic              neg;
  logic [LvlW-1:0]   diff;
  logic [CmpW-1:0]   lim_prod, diff_prod;
  logic [DurProdW-1:0] dur_prod;
  logic [LvlProdW-1:0] lvl_prod;
  logic [StepsW-1:0] steps_dur, steps_lvl;
  logic [DurW-1:0]   diff_aligned;
  logic [DurW-1:0]   div_dividend, div_divisor, quotient;
  logic [bfr_pkg::ITER_W-1:0] div_iters;
  logic              div_done;
  logic [LvlW-1:0]   q_lvl;
  logic [DurW-1:0]   cnt_inc;
  logic [StepsW-1:0] steps_dec;
  logic              fs, fe;

  // magnitude and direction of the requested change
  assign neg          = (in_q.target_level < level_now_q);
  assign diff         = neg ? LvlW'(level_now_q - in_q.target_level)
                            : LvlW'(in_q.target_level - level_now_q);
  assign diff_aligned = {diff, (DurW - LvlW)'(0)};

  // diff > floor(inc * dur / step) is the same as diff * step > inc * dur
  assign lim_prod  = CmpW'(in_q.duration_ms) * CmpW'(MinIncrement);
  assign diff_prod = CmpW'(diff) * CmpW'(StepTimeMs);

  // both step counts; dur / step is only taken when it is the smaller one,
  // so it always fits the step width
  assign dur_prod  = DurProdW'(in_q.duration_ms) * DurProdW'(DurRecip);
  assign lvl_prod  = LvlProdW'(diff) * LvlProdW'(LvlRecip);
  assign steps_dur = dur_prod[DurShift +: StepsW];
  assign steps_lvl = lvl_prod[LvlShift +: StepsW];

  always_comb begin
    div_dividend = in_q.duration_ms;
    div_divisor  = DurW'(cal_steps_q);
    div_iters    = bfr_pkg::ITER_W'(DurW);
    unique case (cmd_i.div_op)
      bfr_pkg::DIV_INTERVAL: begin
        div_dividend = in_q.duration_ms;
      end
      bfr_pkg::DIV_INC: begin
        div_dividend = diff_aligned;
        div_iters    = bfr_pkg::ITER_W'(LvlW);
      end
      default: begin
        div_dividend = in_q.duration_ms;
      end
    endcase
  end

  bfr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign q_lvl = quotient[LvlW-1:0];

  // input word register and working registers for a stepped start
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.prep) begin
      big_q <= (diff_prod > lim_prod);
    end
    if (cmd_i.take_steps) begin
      cal_steps_q <= big_q ? steps_dur : steps_lvl;
    end
    if (cmd_i.take_interval) begin
      cal_int_q <= quotient;
    end
    if (cmd_i.take_inc) begin
      cal_delta_q <= neg ? LvlW'(-q_lvl) : q_lvl;
    end
  end

  assign cnt_inc   = tick_cnt_q + 1'b1;
  assign steps_dec = (steps_left_q != '0) ? StepsW'(steps_left_q - 1'b1) : steps_left_q;

  always_comb begin
    level_now_d  = level_now_q;
    level_goal_d = level_goal_q;
    step_delta_d = step_delta_q;
    steps_left_d = steps_left_q;
    tick_int_d   = tick_int_q;
    tick_cnt_d   = tick_cnt_q;
    running_d    = running_q;
    fs           = 1'b0;
    fe           = 1'b0;
    unique case (cmd_i.kind)
      bfr_pkg::COMMIT_TICK: begin
        if (running_q) begin
          if (cnt_inc >= tick_int_q) begin
            tick_cnt_d   = '0;
            steps_left_d = steps_dec;
            if (steps_dec == '0) begin
              level_now_d = level_goal_q;
              running_d   = 1'b0;
              fe          = 1'b1;
            end else begin
              level_now_d = LvlW'(level_now_q + step_delta_q);
            end
          end else begin
            tick_cnt_d = cnt_inc;
          end
        end
      end
      bfr_pkg::COMMIT_SET: begin
        level_now_d = in_q.target_level;
      end
      bfr_pkg::COMMIT_EQUAL: begin
        level_goal_d = in_q.target_level;
        fe           = 1'b1;
      end
      bfr_pkg::COMMIT_JUMP: begin
        level_now_d  = in_q.target_level;
        level_goal_d = in_q.target_level;
        running_d    = 1'b0;
        steps_left_d = '0;
        tick_cnt_d   = '0;
        fe           = 1'b1;
      end
      bfr_pkg::COMMIT_FADE: begin
        level_goal_d = in_q.target_level;
        step_delta_d = cal_delta_q;
        if (!running_q) begin
          tick_int_d = cal_int_q;
        end
        steps_left_d = cal_steps_q;
        tick_cnt_d   = '0;
        running_d    = 1'b1;
        fs           = 1'b1;
      end
      default: begin
        fe = 1'b0;
      end
    endcase
    out_d.brightness = level_now_d;
    out_d.fade_start = fs;
    out_d.fade_end   = fe;
    out_d.fading     = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_now_q  <= '0;
      level_goal_q <= '0;
      step_delta_q <= '0;
      steps_left_q <= '0;
      tick_int_q   <= '0;
      tick_cnt_q   <= '0;
      running_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        level_now_q  <= level_now_d;
        level_goal_q <= level_goal_d;
        step_delta_q <= step_delta_d;
        steps_left_q <= steps_left_d;
        tick_int_q   <= tick_int_d;
        tick_cnt_q   <= tick_cnt_d;
        running_q    <= running_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign sts_o.action      = in_q.action;
  assign sts_o.at_goal     = (in_q.target_level == level_now_q);
  assign sts_o.running     = running_q;
  assign sts_o.steps_small = (cal_steps_q < StepsW'(bfr_pkg::MIN_STEPS));
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/bfr_ctrl.sv =====
// fader sequencer: decodes the word and steps the divider passes
module bfr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bfr_pkg::ctrl_sts_t sts_i,
  output bfr_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_COMMIT     = 4'd2;
  localparam logic [3:0] S_STEPS      = 4'd3;
  localparam logic [3:0] S_CHECK      = 4'd4;
  localparam logic [3:0] S_INT_GO     = 4'd5;
  localparam logic [3:0] S_INT_WAIT   = 4'd6;
  localparam logic [3:0] S_INC_GO     = 4'd7;
  localparam logic [3:0] S_INC_WAIT   = 4'd8;

  logic [3:0]       state_q, state_d;
  bfr_pkg::commit_e kind_q, kind_d;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    cmd_o        = '0;
    cmd_o.div_op = bfr_pkg::DIV_INTERVAL;
    cmd_o.kind   = kind_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_COMMIT;
        case (sts_i.action)
          bfr_pkg::ACT_TICK: kind_d = bfr_pkg::COMMIT_TICK;
          bfr_pkg::ACT_SET:  kind_d = bfr_pkg::COMMIT_SET;
          bfr_pkg::ACT_START: begin
            if (sts_i.at_goal) begin
              kind_d = bfr_pkg::COMMIT_EQUAL;
            end else begin
              cmd_o.prep = 1'b1;
              state_d    = S_STEPS;
            end
          end
          default: kind_d = bfr_pkg::COMMIT_NONE;
        endcase
      end
      S_STEPS: begin
        cmd_o.take_steps = 1'b1;
        state_d          = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.steps_small) begin
          kind_d  = bfr_pkg::COMMIT_JUMP;
          state_d = S_COMMIT;
        end else if (sts_i.running) begin
          state_d = S_INC_GO;
        end else begin
          state_d = S_INT_GO;
        end
      end
      S_INT_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = bfr_pkg::DIV_INTERVAL;
        state_d         = S_INT_WAIT;
      end
      S_INT_WAIT: begin
        cmd_o.div_op = bfr_pkg::DIV_INTERVAL;
        if (sts_i.div_done) begin
          cmd_o.take_interval = 1'b1;
          state_d             = S_INC_GO;
        end
      end
      S_INC_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = bfr_pkg::DIV_INC;
        state_d         = S_INC_WAIT;
      end
      S_INC_WAIT: begin
        cmd_o.div_op = bfr_pkg::DIV_INC;
        if (sts_i.div_done) begin
          cmd_o.take_inc = 1'b1;
          kind_d         = bfr_pkg::COMMIT_FADE;
          state_d        = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= bfr_pkg::COMMIT_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== rtl/brightness_fade_ramp_unit.sv =====
// top level of the linear brightness fader
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (action, target,
//          |           |                         |             duration)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (brightness,
//          |           |                         |             flags)
//
// one word in, one word out; a word is worked on alone
// path from accept to result: tick, direct set, unchanged target and unknown action
//   go from decode straight to the result write; a jump (fewer than three steps)
//   also takes the step count and its check; a stepped start adds the divider passes
// the step count comes from a reciprocal multiply; the one-bit-per-cycle divider
//   then runs for the tick interval (20 bits, skipped on a retarget) and the increment
// reset clears the whole fade state to brightness zero, idle
// a result waiting in the output register holds only the final write stage;
//   the next word is accepted as soon as the sequencer is back in idle
module brightness_fade_ramp_unit #(
  parameter int StepTimeMs   = bfr_pkg::STEP_TIME_MS,
  parameter int MinIncrement = bfr_pkg::MIN_INCREMENT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bfr_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bfr_pkg::out_word_t out_data_o
);

  // command and status between sequencer and datapath
  bfr_pkg::ctrl_cmd_t cmd;
  bfr_pkg::ctrl_sts_t sts;

  // sequencer: owns the input handshake and orders the divider passes
  bfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: fade state, divider, and the output register
  bfr_dp #(
    .StepTimeMs   (StepTimeMs),
    .MinIncrement (MinIncrement)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/fade_checker.sv =====
// checker for the brightness fader: predicts each output word and compares it
module fade_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  bfr_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  bfr_pkg::out_word_t out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 fades_begun_o,
  output int                 fades_done_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfr_pkg::*;

  localparam int DUR_MASK  = (1 << DUR_W) - 1;
  localparam int PRINT_CAP = 100;

  // predicted fader state
  logic [LVL_W-1:0] lvl_cur;
  logic [LVL_W-1:0] lvl_goal;
  logic [LVL_W-1:0] step_inc;
  int               steps_rem;
  int               interval;
  int               tick_cnt;
  logic             fading_st;

  out_word_t        want_q[$];
  out_word_t        want_w;
  int               n_checked;

  task automatic report_mismatch(input string what, input logic [LVL_W-1:0] got,
                                 input logic [LVL_W-1:0] want);
    if (errors_o < PRINT_CAP)
      $display("word %0d: %s is %h, expected %h", n_checked, what, got, want);
    errors_o++;
  endtask

  // one input word against the fader state, returns the word it must produce
  function automatic out_word_t fade_step(input in_word_t w);
    out_word_t r;
    int        t_i, l_i, dur, sd, mag, lim, nst, inc;
    logic      was_eq;
    r = '0;
    case (w.action)
      ACT_TICK: begin
        if (fading_st) begin
          tick_cnt = (tick_cnt + 1) & DUR_MASK;
          if (tick_cnt >= interval) begin
            tick_cnt = 0;
            lvl_cur  = lvl_cur + step_inc;
            if (steps_rem > 0) steps_rem--;
            if (steps_rem == 0) begin
              lvl_cur    = lvl_goal;
              fading_st  = 1'b0;
              r.fade_end = 1'b1;
              fades_done_o++;
            end
          end
        end
      end
      ACT_START: begin
        was_eq   = (w.target_level == lvl_cur);
        lvl_goal = w.target_level;
        if (!was_eq) begin
          t_i = int'(w.target_level);
          l_i = int'(lvl_cur);
          dur = int'(w.duration_ms);
          sd  = t_i - l_i;
          mag = (sd < 0) ? -sd : sd;
          lim = (MIN_INCREMENT * dur) / STEP_TIME_MS;
          nst = (mag > lim) ? dur / STEP_TIME_MS : mag / MIN_INCREMENT;
          if (nst < MIN_STEPS) begin
            // too few steps: jump and drop any running fade
            lvl_cur   = w.target_level;
            fading_st = 1'b0;
            steps_rem = 0;
            tick_cnt  = 0;
          end else begin
            inc      = sd / nst;
            step_inc = inc[LVL_W-1:0];
            // a retarget keeps the interval of the fade in progress
            if (!fading_st) interval = (dur / nst) & DUR_MASK;
            steps_rem = nst;
            tick_cnt  = 0;
            fading_st = 1'b1;
          end
        end
        if (was_eq || !fading_st) begin
          r.fade_end = 1'b1;
        end else begin
          r.fade_start = 1'b1;
          fades_begun_o++;
        end
      end
      ACT_SET: begin
        lvl_cur = w.target_level;
      end
      default: ;
    endcase
    r.brightness = lvl_cur;
    r.fading     = fading_st;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_cur       = '0;
      lvl_goal      = '0;
      step_inc      = '0;
      steps_rem     = 0;
      interval      = 0;
      tick_cnt      = 0;
      fading_st     = 1'b0;
      want_q.delete();
      n_checked     = 0;
      errors_o      = 0;
      pending_o     = 0;
      fades_begun_o = 0;
      fades_done_o  = 0;
    end else begin
      // retire first, then predict: a new word may be taken on the edge
      // that the previous result leaves
      if (out_valid_i && out_ready_i) begin
        if (want_q.size() == 0) begin
          report_mismatch("unexpected word, brightness", out_data_i.brightness, 'x);
        end else begin
          want_w = want_q.pop_front();
          if (out_data_i.brightness !== want_w.brightness)
            report_mismatch("brightness", out_data_i.brightness, want_w.brightness);
          if (out_data_i.fade_start !== want_w.fade_start)
            report_mismatch("fade_start", LVL_W'(out_data_i.fade_start),
                            LVL_W'(want_w.fade_start));
          if (out_data_i.fade_end !== want_w.fade_end)
            report_mismatch("fade_end", LVL_W'(out_data_i.fade_end),
                            LVL_W'(want_w.fade_end));
          if (out_data_i.fading !== want_w.fading)
            report_mismatch("fading", LVL_W'(out_data_i.fading), LVL_W'(want_w.fading));
        end
        n_checked++;
      end
      if (in_valid_i && in_ready_i) want_q.push_back(fade_step(in_data_i));
      pending_o = want_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// testbench top of the brightness fader: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfr_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int N_WORDS      = 1150;
  localparam int QUIET_WORDS  = 100;     // tail of the run with no idling
  localparam int LONG_HOLD    = 300;     // one long receiver stall, in cycles
  localparam int DRAIN_CYCLES = 80;      // longer than a full stepped start
  localparam int CYCLE_LIMIT  = 500000;

  // the block ignores this action code; it still answers with its state
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;

  int        errors, pending, fades_begun, fades_done;
  int        n_sent    = 0;
  int        cycles    = 0;
  bit        quiet     = 1'b0;   // set near the end: neither side idles
  bit        calm      = 1'b0;   // per sequence: the sender does not idle
  bit        held_long = 1'b0;

  brightness_fade_ramp_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  fade_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .errors_o      (errors),
    .pending_o     (pending),
    .fades_begun_o (fades_begun),
    .fades_done_o  (fades_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // hard stop in case the block hangs or drops a word
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("no progress after %0d cycles, %0d words still owed", cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long stall early on so that the
  // output register fills and the block stops taking words
  initial begin : rx_side
    int n;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_long && n_sent >= 40) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one word from a falling edge, hold it until taken, and return on
  // the next falling edge so the caller can drive straight away
  task automatic put_word(input logic [ACT_W-1:0] act, input logic [LVL_W-1:0] lvl,
                          input logic [DUR_W-1:0] dur);
    in_word_t w;
    int       gap;
    w.action       = act;
    w.target_level = lvl;
    w.duration_ms  = dur;
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    quiet = (n_sent >= N_WORDS - QUIET_WORDS);
    @(negedge clk);
  endtask

  // sender stays quiet until every word sent has been answered
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly short and mid durations, now and then anything the field holds
  function automatic logic [DUR_W-1:0] pick_dur();
    logic [DUR_W-1:0] d;
    case ($urandom_range(0, 3))
      0:       d = DUR_W'($urandom);
      1:       d = DUR_W'($urandom_range(0, 1000));
      2:       d = DUR_W'($urandom_range(300, 40000));
      default: d = DUR_W'($urandom_range(0, 700));
    endcase
    return d;
  endfunction

  // any action with random fields, the unknown code included
  task automatic put_noise();
    logic [ACT_W-1:0] act;
    act = ACT_W'($urandom_range(0, 3));
    put_word(act, LVL_W'($urandom), pick_dur());
  endtask

  initial begin : tx_side
    int               k, len;
    logic [DUR_W-1:0] dur;
    logic             short_fade;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: walk the special cases from the reset level of zero
    put_word(ACT_TICK,  8'hFF,   20'hFFFFF);  // tick while idle does nothing
    put_word(ACT_NONE,  8'hAA,   20'h55555);  // unknown action
    put_word(ACT_START, 8'h00,   20'h00000);  // target already reached
    put_word(ACT_SET,   8'hFF,   20'h00000);  // direct set to full
    put_word(ACT_START, 8'h00,   20'h00000);  // no duration: jump down
    put_word(ACT_START, 8'h01,   20'd150);    // step count from the level, zero
    put_word(ACT_START, 8'hFF,   20'hFFFFF);  // longest fade, 127 steps of 2
    put_word(ACT_TICK,  8'h00,   20'h00000);
    put_word(ACT_START, 8'h01,   20'd300);    // same level while fading: goal only
    put_word(ACT_START, 8'd100,  20'd400);    // retarget keeps the old interval
    put_word(ACT_SET,   8'd250,  20'hFFFFF);  // direct set does not stop the fade
    put_word(ACT_START, 8'd10,   20'd200);    // two steps: jump, fade cancelled
    put_word(ACT_START, 8'd200,  20'd300);    // exactly three steps, interval 100
    put_word(ACT_SET,   8'd250,  20'd0);      // next step will wrap past 255
    put_word(ACT_START, 8'd5,    20'h80000);  // downward retarget, increment of 2
    put_word(ACT_START, 8'd0,    20'd0);      // cancel
    put_word(ACT_START, 8'd60,   20'd100000); // fresh start, steps from the level
    put_word(ACT_START, 8'd55,   20'd1000);   // upward retarget from zero, steps from the duration
    put_word(ACT_NONE,  8'h55,   20'hAAAAA);  // unknown action while a fade runs
    put_word(ACT_TICK,  8'hAA,   20'h55555);
    drain();

    // random: mostly a start followed by a run of ticks, with a little noise
    // mixed in; short durations give at most three steps, which a run can finish
    while (n_sent < N_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 1)) put_word(ACT_SET, LVL_W'($urandom), DUR_W'($urandom));
          short_fade = 1'($urandom_range(0, 1));
          if (short_fade) dur = DUR_W'($urandom_range(300, 399));
          else if ($urandom_range(0, 1)) dur = DUR_W'($urandom_range(400, 1500));
          else dur = pick_dur();
          put_word(ACT_START, LVL_W'($urandom), dur);
          len = short_fade ? $urandom_range(300, 420) : $urandom_range(20, 200);
          for (k = 0; k < len && n_sent < N_WORDS; k++) begin
            if ($urandom_range(0, 99) == 0) put_noise();
            else put_word(ACT_TICK, LVL_W'($urandom), DUR_W'($urandom));
          end
        end
        6: begin
          if (!quiet) drain();
        end
        default: begin
          len = $urandom_range(1, 8);
          for (k = 0; k < len; k++) put_noise();
        end
      endcase
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d words sent; %0d stepped fades started or retargeted, %0d ran to the end",
             n_sent, fades_begun, fades_done);
    $display("receiver held off for %0d cycles once; both sides idled at random", LONG_HOLD);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
